// ===== hw/rtl/xts_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// XML tag scanner package
// Shared types, character codes and prefix patterns.
// ----------------------------------------------------------------------------
package xts_pkg;

    localparam logic [7:0] LT_CHAR      = 8'h3C;
    localparam logic [7:0] GT_CHAR      = 8'h3E;
    localparam logic [7:0] DASH_CHAR    = 8'h2D;
    localparam logic [7:0] BRACKET_CHAR = 8'h5D;

    localparam logic [3:0] COMMENT_LEN = 4'd3;
    localparam logic [3:0] CDATA_LEN   = 4'd8;
    localparam logic [3:0] COMMENT_MIN = 4'd5;
    localparam logic [3:0] CDATA_MIN   = 4'd10;
    localparam logic [3:0] COUNT_MAX   = 4'd15;

    typedef enum logic [1:0] {
        MODE_OUTSIDE = 2'd0,
        MODE_TAG     = 2'd1,
        MODE_COMMENT = 2'd2,
        MODE_CDATA   = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        EV_TEXT    = 3'd0,
        EV_OPEN    = 3'd1,
        EV_TAGBYTE = 3'd2,
        EV_CLOSE   = 3'd3,
        EV_CANCEL  = 3'd4,
        EV_SKIPPED = 3'd5,
        EV_SKIPEND = 3'd6,
        EV_ERROR   = 3'd7
    } event_t;

    typedef struct packed {
        event_t     ev;
        logic [7:0] tag_byte;
    } result_t;

    // "!--"
    function automatic logic [7:0] comment_char(input logic [1:0] idx);
        logic [7:0] c;
        case (idx)
            2'd0:    c = 8'h21;
            2'd1:    c = 8'h2D;
            2'd2:    c = 8'h2D;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // "![CDATA["
    function automatic logic [7:0] cdata_char(input logic [2:0] idx);
        logic [7:0] c;
        case (idx)
            3'd0:    c = 8'h21;
            3'd1:    c = 8'h5B;
            3'd2:    c = 8'h43;
            3'd3:    c = 8'h44;
            3'd4:    c = 8'h41;
            3'd5:    c = 8'h54;
            3'd6:    c = 8'h41;
            3'd7:    c = 8'h5B;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

// ===== hw/rtl/xts_in_stage.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// XML tag scanner input stage
// Registers one input beat; refills in the cycle the held beat moves on.
// ----------------------------------------------------------------------------
module xts_in_stage
    import xts_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] data_byte,
    input  logic       advance,
    output logic       held_valid,
    output logic [7:0] held_byte
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;

    assign in_ready   = !valid_reg || advance;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            byte_reg <= data_byte;
        end
    end

    assign held_valid = valid_reg;
    assign held_byte  = byte_reg;

endmodule

// ===== hw/rtl/xts_classify.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// XML tag scanner classifier
// Scan state and the per-byte event decision.
// ----------------------------------------------------------------------------
module xts_classify
    import xts_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step,
    input  logic [7:0] data_byte,
    output result_t    result
);

    mode_t      mode_reg, mode_next;
    logic [3:0] count_reg, count_next;
    logic       cmt_ok_reg, cmt_ok_next;
    logic       cdata_ok_reg, cdata_ok_next;
    logic [7:0] prev_reg, prev_next;
    logic [7:0] prev2_reg, prev2_next;

    logic [3:0] count_inc;
    logic       cmt_ok_upd;
    logic       cdata_ok_upd;
    logic [7:0] mark;
    logic [3:0] limit;

    assign count_inc = (count_reg < COUNT_MAX) ? count_reg + 4'd1 : count_reg;

    always_comb
    begin
        cmt_ok_upd = cmt_ok_reg;
        if (count_reg < COMMENT_LEN && data_byte != comment_char(count_reg[1:0]))
        begin
            cmt_ok_upd = 1'b0;
        end
        cdata_ok_upd = cdata_ok_reg;
        if (count_reg < CDATA_LEN && data_byte != cdata_char(count_reg[2:0]))
        begin
            cdata_ok_upd = 1'b0;
        end
    end

    assign mark  = (mode_reg == MODE_COMMENT) ? DASH_CHAR : BRACKET_CHAR;
    assign limit = (mode_reg == MODE_COMMENT) ? COMMENT_MIN : CDATA_MIN;

    always_comb
    begin
        mode_next       = mode_reg;
        count_next      = count_reg;
        cmt_ok_next     = cmt_ok_reg;
        cdata_ok_next   = cdata_ok_reg;
        prev_next       = prev_reg;
        prev2_next      = prev2_reg;
        result.ev       = EV_TEXT;
        result.tag_byte = 8'h00;
        case (mode_reg)
            MODE_OUTSIDE:
            begin
                if (data_byte == LT_CHAR)
                begin
                    mode_next = MODE_TAG;
                    result.ev = EV_OPEN;
                end
                else if (data_byte == GT_CHAR)
                begin
                    result.ev = EV_ERROR;
                end
            end
            MODE_TAG:
            begin
                if (data_byte == LT_CHAR || data_byte == GT_CHAR)
                begin
                    mode_next     = MODE_OUTSIDE;
                    count_next    = 4'd0;
                    cmt_ok_next   = 1'b1;
                    cdata_ok_next = 1'b1;
                    prev_next     = 8'h00;
                    prev2_next    = 8'h00;
                    result.ev     = (data_byte == LT_CHAR) ? EV_ERROR : EV_CLOSE;
                end
                else
                begin
                    count_next    = count_inc;
                    cmt_ok_next   = cmt_ok_upd;
                    cdata_ok_next = cdata_ok_upd;
                    prev_next     = data_byte;
                    prev2_next    = prev_reg;
                    if (count_inc == COMMENT_LEN && cmt_ok_upd)
                    begin
                        mode_next = MODE_COMMENT;
                        result.ev = EV_CANCEL;
                    end
                    else if (count_inc == CDATA_LEN && cdata_ok_upd)
                    begin
                        mode_next = MODE_CDATA;
                        result.ev = EV_CANCEL;
                    end
                    else
                    begin
                        result.ev       = EV_TAGBYTE;
                        result.tag_byte = data_byte;
                    end
                end
            end
            default:
            begin
                if (data_byte == GT_CHAR && count_inc > limit &&
                    prev_reg == mark && prev2_reg == mark)
                begin
                    mode_next     = MODE_OUTSIDE;
                    count_next    = 4'd0;
                    cmt_ok_next   = 1'b1;
                    cdata_ok_next = 1'b1;
                    prev_next     = 8'h00;
                    prev2_next    = 8'h00;
                    result.ev     = EV_SKIPEND;
                end
                else
                begin
                    count_next = count_inc;
                    prev_next  = data_byte;
                    prev2_next = prev_reg;
                    result.ev  = EV_SKIPPED;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= MODE_OUTSIDE;
            count_reg    <= 4'd0;
            cmt_ok_reg   <= 1'b1;
            cdata_ok_reg <= 1'b1;
            prev_reg     <= 8'h00;
            prev2_reg    <= 8'h00;
        end
        else if (step)
        begin
            mode_reg     <= mode_next;
            count_reg    <= count_next;
            cmt_ok_reg   <= cmt_ok_next;
            cdata_ok_reg <= cdata_ok_next;
            prev_reg     <= prev_next;
            prev2_reg    <= prev2_next;
        end
    end

endmodule

// ===== hw/rtl/xts_out_stage.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// XML tag scanner output stage
// Result register; takes a new beat whenever empty or being drained.
// ----------------------------------------------------------------------------
module xts_out_stage
    import xts_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       load_valid,
    output logic       load_ready,
    input  result_t    load_result,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [2:0] event_res,
    output logic [7:0] tag_byte
);

    logic    valid_reg;
    logic    valid_next;
    result_t result_reg;

    assign load_ready = !valid_reg || out_ready;
    assign valid_next = load_ready ? load_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_ready && load_valid)
        begin
            result_reg <= load_result;
        end
    end

    assign out_valid = valid_reg;
    assign event_res = 3'(result_reg.ev);
    assign tag_byte  = result_reg.tag_byte;

endmodule

// ===== hw/rtl/xml_tag_boundary_scanner.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// XML tag boundary scanner
// Classifies each byte of an XML stream with one event.
//
//   channel | signals                          | beat
//   --------+----------------------------------+-------------------------
//   input   | in_valid, in_ready, data_byte    | one stream byte
//   output  | out_valid, out_ready, event_res, | one event per byte
//           | tag_byte                         |
//
// One byte per cycle while out_ready keeps the result register draining; each
// byte passes the input register, then the result register.
// Reset (rst_n low, async) empties both registers and returns the scan to
// outside-tag. A stalled output holds its beat; the input register keeps
// taking beats as long as the result register drains.
// ----------------------------------------------------------------------------
module xml_tag_boundary_scanner
    import xts_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] data_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [2:0] event_res,
    output logic [7:0] tag_byte
);

    logic       held_valid;
    logic [7:0] held_byte;
    logic       load_ready;
    logic       advance;
    result_t    cls_result;

    assign advance = held_valid && load_ready;

    xts_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .data_byte  (data_byte),
        .advance    (advance),
        .held_valid (held_valid),
        .held_byte  (held_byte)
    );

    xts_classify u_classify (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .data_byte (held_byte),
        .result    (cls_result)
    );

    xts_out_stage u_out_stage (
        .clk         (clk),
        .rst_n       (rst_n),
        .load_valid  (held_valid),
        .load_ready  (load_ready),
        .load_result (cls_result),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .event_res   (event_res),
        .tag_byte    (tag_byte)
    );

endmodule
